### rtl/core/scc_pkg.sv
// scc_pkg: shared types and constants for the strongly connected component counter
// used by scc_ctrl, scc_dp and scc_counter; no dependencies
`default_nettype none

package scc_pkg;

  // fixed field widths of the ports
  localparam int VTX_W = 10;
  localparam int CNT_W = 11;

  // one input word: at most one directed edge
  typedef struct packed {
    logic [VTX_W-1:0] edge_source;
    logic [VTX_W-1:0] edge_target;
    logic             has_edge;
    logic             last;
  } scc_in_t;

  // one result word
  typedef struct packed {
    logic [CNT_W-1:0] component_count;
    logic             error;
  } scc_out_t;

  // sequencer steps, also the command to the datapath
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_CHK_EV,
    S_CLR,
    S_CNT,
    S_CNT_OF,
    S_CNT_WR,
    S_PFX,
    S_PFX_WR,
    S_END,
    S_FIL,
    S_FIL_OF,
    S_FIL_WR,
    S_OUT,
    S_OUT_FIN,
    S_OUT_CHK,
    S_PUSH1,
    S_PUSH2,
    S_STEP,
    S_NB,
    S_VIS,
    S_POP1,
    S_POP2,
    S_VCLR,
    S_DONE
  } scc_op_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic err;
    logic i_end;
    logic v_end;
    logic o_end;
    logic vis_hit;
    logic c_lt_e;
    logic sp_zero;
    logic rec;
  } scc_status_t;

endpackage

`default_nettype wire

### rtl/core/scc_ctrl.sv
// scc_ctrl: sequencer for loading, row building and the two depth-first walks
// depends on scc_pkg
`default_nettype none

module scc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_last,
  input  wire scc_pkg::scc_status_t st,
  output scc_pkg::scc_op_t         op,
  output logic                     busy
);

  scc_pkg::scc_op_t state_r;
  scc_pkg::scc_op_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    op        = state_r;
    busy      = (state_r != scc_pkg::S_IDLE);
    case (state_r)
      scc_pkg::S_IDLE: begin
        if (start && in_last) state_nxt = scc_pkg::S_CHK;
      end
      scc_pkg::S_CHK: begin
        if (st.err) state_nxt = scc_pkg::S_DONE;
        else if (st.i_end) state_nxt = scc_pkg::S_CLR;
        else state_nxt = scc_pkg::S_CHK_EV;
      end
      scc_pkg::S_CHK_EV: state_nxt = scc_pkg::S_CHK;
      scc_pkg::S_CLR: begin
        if (st.v_end) state_nxt = scc_pkg::S_CNT;
      end
      scc_pkg::S_CNT: begin
        state_nxt = st.i_end ? scc_pkg::S_PFX : scc_pkg::S_CNT_OF;
      end
      scc_pkg::S_CNT_OF: state_nxt = scc_pkg::S_CNT_WR;
      scc_pkg::S_CNT_WR: state_nxt = scc_pkg::S_CNT;
      scc_pkg::S_PFX: begin
        state_nxt = st.v_end ? scc_pkg::S_END : scc_pkg::S_PFX_WR;
      end
      scc_pkg::S_PFX_WR: state_nxt = scc_pkg::S_PFX;
      scc_pkg::S_END:    state_nxt = scc_pkg::S_FIL;
      scc_pkg::S_FIL: begin
        state_nxt = st.i_end ? scc_pkg::S_OUT : scc_pkg::S_FIL_OF;
      end
      scc_pkg::S_FIL_OF: state_nxt = scc_pkg::S_FIL_WR;
      scc_pkg::S_FIL_WR: state_nxt = scc_pkg::S_FIL;
      scc_pkg::S_OUT: begin
        if (st.o_end) state_nxt = st.rec ? scc_pkg::S_VCLR : scc_pkg::S_DONE;
        else state_nxt = scc_pkg::S_OUT_FIN;
      end
      scc_pkg::S_OUT_FIN: state_nxt = scc_pkg::S_OUT_CHK;
      scc_pkg::S_OUT_CHK: begin
        state_nxt = st.vis_hit ? scc_pkg::S_OUT : scc_pkg::S_PUSH1;
      end
      scc_pkg::S_PUSH1: state_nxt = scc_pkg::S_PUSH2;
      scc_pkg::S_PUSH2: state_nxt = scc_pkg::S_STEP;
      scc_pkg::S_STEP: begin
        if (st.c_lt_e) state_nxt = scc_pkg::S_NB;
        else if (st.sp_zero) state_nxt = scc_pkg::S_OUT;
        else state_nxt = scc_pkg::S_POP1;
      end
      scc_pkg::S_NB: state_nxt = scc_pkg::S_VIS;
      scc_pkg::S_VIS: begin
        state_nxt = st.vis_hit ? scc_pkg::S_STEP : scc_pkg::S_PUSH1;
      end
      scc_pkg::S_POP1: state_nxt = scc_pkg::S_POP2;
      scc_pkg::S_POP2: state_nxt = scc_pkg::S_STEP;
      scc_pkg::S_VCLR: begin
        if (st.v_end) state_nxt = scc_pkg::S_OUT;
      end
      scc_pkg::S_DONE: state_nxt = scc_pkg::S_IDLE;
      default: state_nxt = scc_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/scc_dp.sv
// scc_dp: edge store, adjacency rows, visit marks, finish order and walk stack
// depends on scc_pkg; driven by commands from scc_ctrl
`default_nettype none

module scc_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire scc_pkg::scc_op_t    op,
  input  wire logic                in_fire,
  input  wire scc_pkg::scc_in_t    in_word,
  input  wire logic                cfg_we,
  input  wire logic [scc_pkg::CNT_W-1:0] cfg_data,
  output scc_pkg::scc_status_t     st,
  output logic                     out_valid,
  output scc_pkg::scc_out_t        out_word
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int MW = $clog2(MAX_EDGES + 1);

  // memories
  logic [scc_pkg::VTX_W-1:0] ef_mem [MAX_EDGES];
  logic [scc_pkg::VTX_W-1:0] et_mem [MAX_EDGES];
  logic [MW-1:0]             fo_mem [MAX_VERTICES+1];
  logic [MW-1:0]             ro_mem [MAX_VERTICES+1];
  logic [VW-1:0]             fn_mem [MAX_EDGES];
  logic [VW-1:0]             rn_mem [MAX_EDGES];
  logic                      vs_mem [MAX_VERTICES];
  logic [VW-1:0]             fi_mem [MAX_VERTICES];
  logic [VW-1:0]             sv_mem [MAX_VERTICES];
  logic [MW-1:0]             sc_mem [MAX_VERTICES];

  logic [scc_pkg::VTX_W-1:0] ef_q, et_q;
  logic [MW-1:0]             fo_q, ro_q, off_q;
  logic [VW-1:0]             fn_q, rn_q, nb_q;
  logic                      vs_q;
  logic [VW-1:0]             fi_q, sv_q;
  logic [MW-1:0]             sc_q;

  // memory port controls
  logic          e_we;
  logic [EW-1:0] e_wa, e_ra;
  logic          fo_we, ro_we;
  logic [NW-1:0] fo_wa, ro_wa, fo_ra, ro_ra;
  logic [MW-1:0] fo_wd, ro_wd;
  logic          fn_we, rn_we;
  logic [EW-1:0] fn_wa, rn_wa, nb_ra;
  logic [VW-1:0] fn_wd, rn_wd;
  logic          vs_we, vs_wd;
  logic [VW-1:0] vs_wa, vs_ra;
  logic          fi_we;
  logic [VW-1:0] fi_wa, fi_ra;
  logic          sk_we;
  logic [VW-1:0] sk_wa, sk_ra;

  // control registers
  logic [scc_pkg::CNT_W-1:0] vc_r;
  logic [MW-1:0]             m_r;
  logic                      errs_r;
  logic                      out_valid_r;

  // working registers
  scc_pkg::scc_out_t out_r;
  logic [NW-1:0] n_r, v_r, o_r, fcnt_r, sp_r, cnt_r;
  logic [MW-1:0] i_r, accf_r, accr_r, cur_c_r, cur_e_r;
  logic [NW-1:0] kf_r, kt_r;
  logic [VW-1:0] vf_r, vr_r, cur_v_r, w_r;
  logic          err_r, rec_r;

  logic [NW-1:0] n_val;
  logic          full;
  logic [VW-1:0] s_val;

  assign full  = !(32'(m_r) < 32'(MAX_EDGES));
  assign n_val = (32'(vc_r) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_r);
  assign off_q = rec_r ? ro_q : fo_q;
  assign nb_q  = rec_r ? rn_q : fn_q;
  assign s_val = rec_r ? VW'(o_r) : fi_q;

  // status to the sequencer
  assign st.err     = err_r;
  assign st.i_end   = (i_r == m_r);
  assign st.v_end   = (v_r == n_r);
  assign st.o_end   = rec_r ? (o_r == n_r) : (o_r == fcnt_r);
  assign st.vis_hit = vs_q;
  assign st.c_lt_e  = (cur_c_r < cur_e_r);
  assign st.sp_zero = (sp_r == '0);
  assign st.rec     = rec_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // memory addressing per step
  always_comb begin
    e_we  = 1'b0;
    e_wa  = EW'(m_r);
    e_ra  = EW'(i_r);
    fo_we = 1'b0; fo_wa = '0; fo_wd = '0; fo_ra = '0;
    ro_we = 1'b0; ro_wa = '0; ro_wd = '0; ro_ra = '0;
    fn_we = 1'b0; fn_wa = '0; fn_wd = vf_r;
    rn_we = 1'b0; rn_wa = '0; rn_wd = vr_r;
    nb_ra = EW'(cur_c_r);
    vs_we = 1'b0; vs_wa = '0; vs_wd = 1'b0; vs_ra = '0;
    fi_we = 1'b0; fi_wa = VW'(fcnt_r);
    fi_ra = VW'(fcnt_r - NW'(1) - o_r);
    sk_we = 1'b0; sk_wa = VW'(sp_r);
    sk_ra = VW'(sp_r - NW'(1));
    case (op)
      scc_pkg::S_IDLE: begin
        e_we = in_fire && in_word.has_edge && !full;
      end
      scc_pkg::S_CLR: begin
        if (v_r != n_r) begin
          fo_we = 1'b1; fo_wa = v_r;
          ro_we = 1'b1; ro_wa = v_r;
          vs_we = 1'b1; vs_wa = VW'(v_r);
        end
      end
      scc_pkg::S_CNT_OF, scc_pkg::S_FIL_OF: begin
        fo_ra = NW'(ef_q);
        ro_ra = NW'(et_q);
      end
      scc_pkg::S_CNT_WR: begin
        fo_we = 1'b1; fo_wa = kf_r; fo_wd = MW'(fo_q + MW'(1));
        ro_we = 1'b1; ro_wa = kt_r; ro_wd = MW'(ro_q + MW'(1));
      end
      scc_pkg::S_PFX: begin
        fo_ra = v_r;
        ro_ra = v_r;
      end
      scc_pkg::S_PFX_WR: begin
        fo_we = 1'b1; fo_wa = v_r; fo_wd = MW'(accf_r + fo_q);
        ro_we = 1'b1; ro_wa = v_r; ro_wd = MW'(accr_r + ro_q);
      end
      scc_pkg::S_END: begin
        fo_we = 1'b1; fo_wa = n_r; fo_wd = m_r;
        ro_we = 1'b1; ro_wa = n_r; ro_wd = m_r;
      end
      scc_pkg::S_FIL_WR: begin
        fo_we = 1'b1; fo_wa = kf_r; fo_wd = MW'(fo_q - MW'(1));
        ro_we = 1'b1; ro_wa = kt_r; ro_wd = MW'(ro_q - MW'(1));
        fn_we = 1'b1; fn_wa = EW'(fo_q - MW'(1));
        rn_we = 1'b1; rn_wa = EW'(ro_q - MW'(1));
      end
      scc_pkg::S_OUT_FIN: begin
        vs_ra = s_val;
      end
      scc_pkg::S_OUT_CHK: begin
        if (!vs_q) begin
          vs_we = 1'b1; vs_wa = cur_v_r; vs_wd = 1'b1;
        end
        fo_ra = NW'(cur_v_r);
        ro_ra = NW'(cur_v_r);
      end
      scc_pkg::S_PUSH1: begin
        fo_ra = NW'(NW'(cur_v_r) + NW'(1));
        ro_ra = NW'(NW'(cur_v_r) + NW'(1));
      end
      scc_pkg::S_STEP: begin
        if (!(cur_c_r < cur_e_r)) begin
          fi_we = rec_r;
        end
      end
      scc_pkg::S_NB: begin
        vs_ra = nb_q;
      end
      scc_pkg::S_VIS: begin
        if (!vs_q) begin
          vs_we = 1'b1; vs_wa = w_r; vs_wd = 1'b1;
          sk_we = 1'b1;
        end
        fo_ra = NW'(w_r);
        ro_ra = NW'(w_r);
      end
      scc_pkg::S_POP1: begin
        fo_ra = NW'(NW'(sv_q) + NW'(1));
        ro_ra = NW'(NW'(sv_q) + NW'(1));
      end
      scc_pkg::S_VCLR: begin
        if (v_r != n_r) begin
          vs_we = 1'b1; vs_wa = VW'(v_r);
        end
      end
      default: ;
    endcase
  end

  // edge store
  always_ff @(posedge clk) begin
    if (e_we) begin
      ef_mem[e_wa] <= in_word.edge_source;
      et_mem[e_wa] <= in_word.edge_target;
    end
    ef_q <= ef_mem[e_ra];
    et_q <= et_mem[e_ra];
  end

  // row offsets
  always_ff @(posedge clk) begin
    if (fo_we) fo_mem[fo_wa] <= fo_wd;
    fo_q <= fo_mem[fo_ra];
  end

  always_ff @(posedge clk) begin
    if (ro_we) ro_mem[ro_wa] <= ro_wd;
    ro_q <= ro_mem[ro_ra];
  end

  // neighbour lists
  always_ff @(posedge clk) begin
    if (fn_we) fn_mem[fn_wa] <= fn_wd;
    fn_q <= fn_mem[nb_ra];
  end

  always_ff @(posedge clk) begin
    if (rn_we) rn_mem[rn_wa] <= rn_wd;
    rn_q <= rn_mem[nb_ra];
  end

  // visit marks
  always_ff @(posedge clk) begin
    if (vs_we) vs_mem[vs_wa] <= vs_wd;
    vs_q <= vs_mem[vs_ra];
  end

  // finish order
  always_ff @(posedge clk) begin
    if (fi_we) fi_mem[fi_wa] <= cur_v_r;
    fi_q <= fi_mem[fi_ra];
  end

  // walk stack
  always_ff @(posedge clk) begin
    if (sk_we) begin
      sv_mem[sk_wa] <= cur_v_r;
      sc_mem[sk_wa] <= cur_c_r;
    end
    sv_q <= sv_mem[sk_ra];
    sc_q <= sc_mem[sk_ra];
  end

  // configuration, load count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= scc_pkg::CNT_W'(1);
      m_r         <= '0;
      errs_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (op == scc_pkg::S_DONE);
      if (cfg_we) vc_r <= cfg_data;
      if (op == scc_pkg::S_IDLE && in_fire && in_word.has_edge) begin
        if (!full) m_r <= MW'(m_r + MW'(1));
        else errs_r <= 1'b1;
      end
      if (op == scc_pkg::S_DONE) begin
        m_r    <= '0;
        errs_r <= 1'b0;
      end
    end
  end

  // working registers per step
  always_ff @(posedge clk) begin
    case (op)
      scc_pkg::S_IDLE: begin
        if (in_fire && in_word.last) begin
          n_r   <= n_val;
          i_r   <= '0;
          err_r <= errs_r || (in_word.has_edge && full);
        end
      end
      scc_pkg::S_CHK: begin
        if (i_r == m_r) v_r <= '0;
      end
      scc_pkg::S_CHK_EV: begin
        if (32'(ef_q) >= 32'(n_r) || 32'(et_q) >= 32'(n_r)) err_r <= 1'b1;
        i_r <= MW'(i_r + MW'(1));
      end
      scc_pkg::S_CLR: begin
        if (v_r == n_r) i_r <= '0;
        else v_r <= NW'(v_r + NW'(1));
      end
      scc_pkg::S_CNT: begin
        if (i_r == m_r) begin
          v_r    <= '0;
          accf_r <= '0;
          accr_r <= '0;
        end
      end
      scc_pkg::S_CNT_OF: begin
        kf_r <= NW'(ef_q);
        kt_r <= NW'(et_q);
      end
      scc_pkg::S_CNT_WR, scc_pkg::S_FIL_WR: begin
        i_r <= MW'(i_r + MW'(1));
      end
      scc_pkg::S_PFX_WR: begin
        accf_r <= MW'(accf_r + fo_q);
        accr_r <= MW'(accr_r + ro_q);
        v_r    <= NW'(v_r + NW'(1));
      end
      scc_pkg::S_END: begin
        i_r <= '0;
      end
      scc_pkg::S_FIL: begin
        if (i_r == m_r) begin
          o_r    <= '0;
          rec_r  <= 1'b1;
          fcnt_r <= '0;
          cnt_r  <= '0;
        end
      end
      scc_pkg::S_FIL_OF: begin
        kf_r <= NW'(ef_q);
        kt_r <= NW'(et_q);
        vf_r <= VW'(et_q);
        vr_r <= VW'(ef_q);
      end
      scc_pkg::S_OUT: begin
        if (rec_r && o_r == n_r) v_r <= '0;
      end
      scc_pkg::S_OUT_FIN: begin
        cur_v_r <= s_val;
      end
      scc_pkg::S_OUT_CHK: begin
        o_r <= NW'(o_r + NW'(1));
        if (!vs_q) begin
          sp_r <= '0;
          if (!rec_r) cnt_r <= NW'(cnt_r + NW'(1));
        end
      end
      scc_pkg::S_PUSH1: begin
        cur_c_r <= off_q;
      end
      scc_pkg::S_PUSH2, scc_pkg::S_POP2: begin
        cur_e_r <= off_q;
      end
      scc_pkg::S_STEP: begin
        if (cur_c_r < cur_e_r) begin
          cur_c_r <= MW'(cur_c_r + MW'(1));
        end else begin
          if (rec_r) fcnt_r <= NW'(fcnt_r + NW'(1));
          if (sp_r != '0) sp_r <= NW'(sp_r - NW'(1));
        end
      end
      scc_pkg::S_NB: begin
        w_r <= nb_q;
      end
      scc_pkg::S_VIS: begin
        if (!vs_q) begin
          sp_r    <= NW'(sp_r + NW'(1));
          cur_v_r <= w_r;
        end
      end
      scc_pkg::S_POP1: begin
        cur_v_r <= sv_q;
        cur_c_r <= sc_q;
      end
      scc_pkg::S_VCLR: begin
        if (v_r == n_r) begin
          rec_r <= 1'b0;
          o_r   <= '0;
        end else begin
          v_r <= NW'(v_r + NW'(1));
        end
      end
      scc_pkg::S_DONE: begin
        out_r.component_count <= err_r ? '0 : scc_pkg::CNT_W'(cnt_r);
        out_r.error           <= err_r;
      end
      default: ;
    endcase
  end

  // checks
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(m_r) <= 32'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.error) |-> (out_r.component_count == '0))
    else $error("count not zero on error");

  a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (op == scc_pkg::S_STEP) |-> (sp_r < n_r))
    else $error("walk stack deeper than vertex count");

endmodule

`default_nettype wire

### rtl/core/scc_counter.sv
// scc_counter: top level of the strongly connected component counter
// depends on scc_pkg, scc_ctrl and scc_dp
`default_nettype none

// Edges load one word per cycle while busy is low and start is high; a word
// with last set starts the count and holds busy high until the single result
// word appears on out_word with out_valid high for one cycle, which the
// receiver must take then. The count checks the edges, clears the row offsets
// and visit marks over the vertices, counts the edges, builds the prefix sums
// and files the edges, then runs two walk passes, clearing the visit marks
// between them; steps wait on registered reads of work memories with one read
// and one write port each. vertex_count may be written at any time through
// cfg_data and is applied when the count starts.
module scc_counter #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire scc_pkg::scc_in_t           in_word,
  output logic                            out_valid,
  output scc_pkg::scc_out_t               out_word,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [scc_pkg::CNT_W-1:0]  cfg_data
);

  scc_pkg::scc_op_t     op;
  scc_pkg::scc_status_t st;
  logic                 in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  // sequencer
  scc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire),
    .in_last (in_word.last),
    .st      (st),
    .op      (op),
    .busy    (busy)
  );

  // memories and counters
  scc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_fire   (in_fire),
    .in_word   (in_word),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .st        (st),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
